// ----- design/srhc_pkg.sv -----
// shared types, codes and constants of the signature rule header classifier
// no dependencies; used by srhc_rule_match, the top level and the testbench
`default_nettype none

package srhc_pkg;

    // defaults for the top-level parameters
    localparam int RULE_COUNT_DEF = 16;
    localparam int SLOTS_DEF      = 4;

    // four lists per rule: src addr, dst addr, src port, dst port
    localparam int LIST_COUNT = 4;
    localparam logic [1:0] LIST_SRC_ADDR = 2'd0;
    localparam logic [1:0] LIST_DST_ADDR = 2'd1;
    localparam logic [1:0] LIST_SRC_PORT = 2'd2;
    localparam logic [1:0] LIST_DST_PORT = 2'd3;

    // transaction modes
    localparam logic [1:0] MODE_HEADER   = 2'd0;
    localparam logic [1:0] MODE_SLOT     = 2'd1;
    localparam logic [1:0] MODE_CLASSIFY = 2'd2;

    // rule protocol codes
    localparam logic [2:0] PROTO_ANY  = 3'd0;
    localparam logic [2:0] PROTO_IP   = 3'd1;
    localparam logic [2:0] PROTO_TCP  = 3'd2;
    localparam logic [2:0] PROTO_UDP  = 3'd3;
    localparam logic [2:0] PROTO_ICMP = 3'd4;
    localparam logic [2:0] PROTO_DNS  = 3'd5;
    localparam logic [2:0] PROTO_HTTP = 3'd6;

    localparam logic [15:0] PORT_HTTP     = 16'd80;
    localparam logic [15:0] PORT_HTTPS    = 16'd443;
    localparam logic [7:0]  IP_PROTO_ICMP = 8'd1;

    // packet kind bits
    localparam int KIND_IPV4 = 0;
    localparam int KIND_TCP  = 1;
    localparam int KIND_UDP  = 2;
    localparam int KIND_DNS  = 3;

    // stored rule header layout
    localparam int HDR_W         = 16;
    localparam int HDR_VALID     = 0;
    localparam int HDR_BIDIR     = 1;
    localparam int HDR_ANY_LSB   = 2;
    localparam int HDR_NEG_LSB   = 6;
    localparam int HDR_ACT_LSB   = 10;
    localparam int HDR_PROTO_LSB = 13;
    localparam int FLAGS_W       = 13;

    // one range slot inside a rule row: low, high, enable
    localparam int ENTRY_W    = 65;
    localparam int ENT_LO_LSB = 0;
    localparam int ENT_HI_LSB = 32;
    localparam int ENT_EN_BIT = 64;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  rule_index;
        logic [1:0]  list_select;
        logic [1:0]  slot;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [2:0]  rule_protocol;
        logic [12:0] rule_flags;
        logic [3:0]  packet_kind;
        logic [7:0]  ip_protocol;
    } t_in_item;

    typedef struct packed {
        logic       matched;
        logic [3:0] match_index;
        logic [2:0] match_action;
        logic       last;
    } t_out_item;

    // packet as seen by the matcher, ports already cleared when not tcp/udp
    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [3:0]  kind;
        logic [7:0]  ip_protocol;
    } t_packet;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

// ----- design/srhc_chan_if.sv -----
// valid/ready channel carrying one payload per transaction
// payload type is a parameter; used with the types of srhc_pkg
`default_nettype none

interface srhc_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- design/srhc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module srhc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic              i_rd_en,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- design/srhc_rule_match.sv -----
// match of one rule row against a packet: protocol test, range lists, bidir
// depends on srhc_pkg
`default_nettype none

module srhc_rule_match
    import srhc_pkg::*;
#(
    parameter int SLOTS_PER_LIST = SLOTS_DEF,
    localparam int ROW_W = HDR_W + LIST_COUNT * SLOTS_PER_LIST * ENTRY_W
) (
    input  wire logic [ROW_W-1:0] i_row,
    input  wire logic             i_row_valid,
    input  wire t_packet          i_pkt,
    output logic                  o_match
);

    logic [HDR_W-1:0]      w_hdr;
    logic [31:0]           w_val_f [LIST_COUNT];
    logic [31:0]           w_val_r [LIST_COUNT];
    logic [LIST_COUNT-1:0] w_hit_f;
    logic [LIST_COUNT-1:0] w_hit_r;
    logic [LIST_COUNT-1:0] w_ok_f;
    logic [LIST_COUNT-1:0] w_ok_r;
    logic                  w_proto_ok;
    logic                  w_http_port;

    assign w_hdr = i_row_valid ? i_row[HDR_W-1:0] : '0;

    always_comb begin
        w_val_f[LIST_SRC_ADDR] = i_pkt.src_addr;
        w_val_f[LIST_DST_ADDR] = i_pkt.dst_addr;
        w_val_f[LIST_SRC_PORT] = {16'd0, i_pkt.src_port};
        w_val_f[LIST_DST_PORT] = {16'd0, i_pkt.dst_port};
        w_val_r[LIST_SRC_ADDR] = i_pkt.dst_addr;
        w_val_r[LIST_DST_ADDR] = i_pkt.src_addr;
        w_val_r[LIST_SRC_PORT] = {16'd0, i_pkt.dst_port};
        w_val_r[LIST_DST_PORT] = {16'd0, i_pkt.src_port};
    end

    // every slot of every list compared in parallel, both directions
    always_comb begin
        for (int l = 0; l < LIST_COUNT; l++) begin
            w_hit_f[l] = w_hdr[HDR_ANY_LSB + l];
            w_hit_r[l] = w_hdr[HDR_ANY_LSB + l];
            for (int s = 0; s < SLOTS_PER_LIST; s++) begin
                if (i_row[HDR_W + (l * SLOTS_PER_LIST + s) * ENTRY_W + ENT_EN_BIT]
                    && w_val_f[l] >= i_row[HDR_W + (l * SLOTS_PER_LIST + s) * ENTRY_W
                                           + ENT_LO_LSB +: 32]
                    && w_val_f[l] <= i_row[HDR_W + (l * SLOTS_PER_LIST + s) * ENTRY_W
                                           + ENT_HI_LSB +: 32]) begin
                    w_hit_f[l] = 1'b1;
                end
                if (i_row[HDR_W + (l * SLOTS_PER_LIST + s) * ENTRY_W + ENT_EN_BIT]
                    && w_val_r[l] >= i_row[HDR_W + (l * SLOTS_PER_LIST + s) * ENTRY_W
                                           + ENT_LO_LSB +: 32]
                    && w_val_r[l] <= i_row[HDR_W + (l * SLOTS_PER_LIST + s) * ENTRY_W
                                           + ENT_HI_LSB +: 32]) begin
                    w_hit_r[l] = 1'b1;
                end
            end
            w_ok_f[l] = w_hit_f[l] ^ w_hdr[HDR_NEG_LSB + l];
            w_ok_r[l] = w_hit_r[l] ^ w_hdr[HDR_NEG_LSB + l];
        end
    end

    assign w_http_port = (i_pkt.dst_port == PORT_HTTP) || (i_pkt.dst_port == PORT_HTTPS)
                      || (i_pkt.src_port == PORT_HTTP) || (i_pkt.src_port == PORT_HTTPS);

    always_comb begin
        case (w_hdr[HDR_PROTO_LSB +: 3])
            PROTO_ANY:  w_proto_ok = 1'b1;
            PROTO_IP:   w_proto_ok = i_pkt.kind[KIND_IPV4];
            PROTO_TCP:  w_proto_ok = i_pkt.kind[KIND_IPV4] & i_pkt.kind[KIND_TCP];
            PROTO_UDP:  w_proto_ok = i_pkt.kind[KIND_IPV4] & i_pkt.kind[KIND_UDP];
            PROTO_ICMP: w_proto_ok = i_pkt.kind[KIND_IPV4]
                                   & (i_pkt.ip_protocol == IP_PROTO_ICMP);
            PROTO_DNS:  w_proto_ok = i_pkt.kind[KIND_IPV4] & i_pkt.kind[KIND_DNS];
            PROTO_HTTP: w_proto_ok = i_pkt.kind[KIND_IPV4] & i_pkt.kind[KIND_TCP]
                                   & w_http_port;
            default:    w_proto_ok = 1'b0;
        endcase
    end

    assign o_match = w_hdr[HDR_VALID] & w_proto_ok & i_pkt.kind[KIND_IPV4]
                   & ((&w_ok_f) | (w_hdr[HDR_BIDIR] & (&w_ok_r)));

endmodule

`default_nettype wire

// ----- design/signature_rule_header_classifier.sv -----
// top level of the signature rule header classifier: rule table in one ram,
// sequential scan over the rules per packet
// depends on srhc_pkg, srhc_chan_if, srhc_ram and srhc_rule_match
//
//  channel    dir  payload      meaning
//  i_item     in   t_in_item    header write, slot write or packet to classify
//  o_result   out  t_out_item   one matching rule, or the no-match result
//
// a header or slot write reads the row, then writes the modified row back
// a classify reads one rule row from the ram per cycle while the scan is not stalled,
// evaluates each row in the cycle after its read, then ends in a flush state
// out-of-range writes and unused modes are accepted and touch nothing
// synchronous active-low reset clears all rules (per-row valid bits); no sweep
// a full output register stalls the scan only when a second match needs to leave
`default_nettype none

module signature_rule_header_classifier
    import srhc_pkg::*;
#(
    parameter int RULE_COUNT     = RULE_COUNT_DEF,
    parameter int SLOTS_PER_LIST = SLOTS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    srhc_chan_if.sink    i_item,
    srhc_chan_if.source  o_result
);

    localparam int IDX_W  = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
    localparam int SLOT_W = (SLOTS_PER_LIST > 1) ? $clog2(SLOTS_PER_LIST) : 1;
    localparam int ROW_W  = HDR_W + LIST_COUNT * SLOTS_PER_LIST * ENTRY_W;

    // control
    t_state                r_state;
    t_state                n_state;
    logic [IDX_W-1:0]      r_idx;
    logic [RULE_COUNT-1:0] r_valid;

    // latched transaction and packet
    t_in_item              r_cmd;
    t_packet               r_pkt;

    // match held back until the next one (or the end) tells whether it is last
    logic                  r_pend_valid;
    logic [3:0]            r_pend_index;
    logic [2:0]            r_pend_action;

    // output register
    logic                  r_out_valid;
    t_out_item             r_out;

    // ram access
    logic                  w_rd_en;
    logic [IDX_W-1:0]      w_rd_addr;
    logic [ROW_W-1:0]      w_rd_data;
    logic                  w_wr_en;
    logic [ROW_W-1:0]      w_wr_row;

    logic                  w_accept;
    logic                  w_idx_ok;
    logic                  w_slot_ok;
    logic                  w_wr_ok;
    logic                  w_is_classify;
    logic                  w_row_match;
    logic                  w_out_free;
    logic                  w_stall;
    logic                  w_advance;
    logic                  w_last_row;
    logic                  w_push;
    t_out_item             w_push_item;

    assign w_accept      = i_item.valid & i_item.ready;
    assign w_idx_ok      = 7'(i_item.payload.rule_index) < 7'(RULE_COUNT);
    assign w_slot_ok     = 5'(i_item.payload.slot) < 5'(SLOTS_PER_LIST);
    assign w_wr_ok       = ((i_item.payload.mode == MODE_HEADER) && w_idx_ok)
                        || ((i_item.payload.mode == MODE_SLOT) && w_idx_ok && w_slot_ok);
    assign w_is_classify = i_item.payload.mode == MODE_CLASSIFY;

    assign w_out_free = !r_out_valid || o_result.ready;
    // a second match can only move on once the held one has left
    assign w_stall    = w_row_match & r_pend_valid & !w_out_free;
    assign w_advance  = !w_stall;
    assign w_last_row = r_idx == IDX_W'(RULE_COUNT - 1);

    srhc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (RULE_COUNT)
    ) u_rule_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (IDX_W'(r_cmd.rule_index)),
        .i_wr_data (w_wr_row),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    srhc_rule_match #(
        .SLOTS_PER_LIST (SLOTS_PER_LIST)
    ) u_match (
        .i_row       (w_rd_data),
        .i_row_valid (r_valid[r_idx]),
        .i_pkt       (r_pkt),
        .o_match     (w_row_match)
    );

    // read-modify-write of one rule row; a never-written row starts from zero
    always_comb begin
        w_wr_row = r_valid[IDX_W'(r_cmd.rule_index)] ? w_rd_data : '0;
        if (r_cmd.mode == MODE_HEADER) begin
            w_wr_row[HDR_W-1:0] = {r_cmd.rule_protocol, r_cmd.rule_flags};
        end else begin
            for (int l = 0; l < LIST_COUNT; l++) begin
                for (int s = 0; s < SLOTS_PER_LIST; s++) begin
                    if (r_cmd.list_select == 2'(l) && SLOT_W'(r_cmd.slot) == SLOT_W'(s)) begin
                        w_wr_row[HDR_W + (l * SLOTS_PER_LIST + s) * ENTRY_W +: ENTRY_W] =
                            {r_cmd.rule_flags[0], r_cmd.value_b, r_cmd.value_a};
                    end
                end
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && w_wr_ok) begin
                    n_state = ST_WRITE;
                end else if (w_accept && w_is_classify) begin
                    n_state = ST_SCAN;
                end
            end
            ST_WRITE: begin
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (w_advance && w_last_row) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_item.ready = 1'b0;
        w_rd_en      = 1'b0;
        w_rd_addr    = '0;
        w_wr_en      = 1'b0;
        w_push       = 1'b0;
        w_push_item  = '0;
        case (r_state)
            ST_IDLE: begin
                i_item.ready = 1'b1;
                if (w_accept && w_wr_ok) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = IDX_W'(i_item.payload.rule_index);
                end else if (w_accept && w_is_classify) begin
                    w_rd_en = 1'b1;
                end
            end
            ST_WRITE: begin
                w_wr_en = 1'b1;
            end
            ST_SCAN: begin
                if (w_advance && !w_last_row) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx + IDX_W'(1);
                end
                // a new match pushes out the held one, which is then not last
                w_push      = w_row_match & r_pend_valid & w_out_free;
                w_push_item = '{matched: 1'b1, match_index: r_pend_index,
                                match_action: r_pend_action, last: 1'b0};
            end
            ST_FLUSH: begin
                w_push = w_out_free;
                if (r_pend_valid) begin
                    w_push_item = '{matched: 1'b1, match_index: r_pend_index,
                                    match_action: r_pend_action, last: 1'b1};
                end else begin
                    w_push_item = '{matched: 1'b0, match_index: 4'd0,
                                    match_action: 3'd0, last: 1'b1};
                end
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_IDLE && w_accept && w_is_classify) begin
                r_idx        <= '0;
                r_pend_valid <= 1'b0;
            end else if (r_state == ST_SCAN && w_advance) begin
                if (!w_last_row) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
                if (w_row_match) begin
                    r_pend_valid <= 1'b1;
                end
            end else if (r_state == ST_FLUSH && w_out_free) begin
                r_pend_valid <= 1'b0;
            end

            if (r_state == ST_WRITE) begin
                r_valid[IDX_W'(r_cmd.rule_index)] <= 1'b1;
            end

            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_item.payload;
        end
        if (w_accept && w_is_classify) begin
            r_pkt.src_addr    <= i_item.payload.value_a;
            r_pkt.dst_addr    <= i_item.payload.value_b;
            r_pkt.kind        <= i_item.payload.packet_kind;
            r_pkt.ip_protocol <= i_item.payload.ip_protocol;
            // ports only count for tcp or udp
            if (i_item.payload.packet_kind[KIND_TCP] || i_item.payload.packet_kind[KIND_UDP]) begin
                r_pkt.src_port <= i_item.payload.src_port;
                r_pkt.dst_port <= i_item.payload.dst_port;
            end else begin
                r_pkt.src_port <= 16'd0;
                r_pkt.dst_port <= 16'd0;
            end
        end
        if (r_state == ST_SCAN && w_advance && w_row_match) begin
            r_pend_index  <= 4'(r_idx);
            r_pend_action <= w_rd_data[HDR_ACT_LSB +: 3];
        end
        if (w_push) begin
            r_out <= w_push_item;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // a write-back always returns straight to idle
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WRITE |=> r_state == ST_IDLE)
        else $error("write-back did not return to idle");

    // a no-match result never leaves while a match is held
    a_nomatch_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_push_item.matched) |-> !r_pend_valid)
        else $error("no-match result with a held match");

    // a match pushed during the scan is replaced by the one that caused it
    a_pend_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && w_push) |=> r_pend_valid)
        else $error("held match lost after push");

    // the flush always ends the run with a last result in the output register
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && w_out_free) |=> (r_out_valid && r_out.last))
        else $error("run ended without last result");

    // scan index stays inside the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_idx <= IDX_W'(RULE_COUNT - 1))
        else $error("scan index beyond rule table");

endmodule

`default_nettype wire

// ----- sim/tb_signature_rule_header_classifier.sv -----
// self-checking testbench for signature_rule_header_classifier: directed table, then random
// rule tables and packets, checked against set verdicts or an in-bench copy of the matcher
// depends on design/srhc_pkg.sv, design/srhc_chan_if.sv and the classifier rtl
module tb_signature_rule_header_classifier
    import srhc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RULES    = RULE_COUNT_DEF;
    localparam int SLOTS        = SLOTS_DEF;
    localparam int MAX_VERDICTS = 16;

    // run shape
    localparam int RANDOM_ITEMS   = 360;
    localparam int QUIET_TAIL     = 50;    // last transactions with no random gaps or stalls
    localparam int LONG_HOLD      = 400;   // receiver back-pressure stretch, in cycles
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either side
    localparam int END_SETTLE     = NUM_RULES + 8;

    // codes the package does not name
    localparam logic [1:0] MODE_UNUSED    = 2'd3;
    localparam logic [2:0] PROTO_RESERVED = 3'd7;
    localparam logic [2:0] ACT_ALERT      = 3'd0;
    localparam logic [2:0] ACT_PASS       = 3'd1;
    localparam logic [2:0] ACT_LOG        = 3'd4;
    localparam logic [2:0] ACT_UNDEF_LO   = 3'd5;
    localparam logic [2:0] ACT_UNDEF_HI   = 3'd7;

    // packet kind combinations used by the directed table
    localparam logic [3:0] KIND_V4_ONLY = 4'b0001;
    localparam logic [3:0] KIND_V4_TCP  = 4'b0011;
    localparam logic [3:0] KIND_V4_UDP  = 4'b0101;
    localparam logic [3:0] KIND_V4_DNS  = 4'b1001;
    localparam logic [3:0] KIND_NO_V4   = 4'b1110;
    localparam logic [3:0] KIND_ALL     = 4'b1111;

    localparam t_out_item NO_MATCH = '{matched: 1'b0, match_index: 4'd0,
                                       match_action: 3'd0, last: 1'b1};

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_step;

    logic i_clk;
    logic i_rst_n;

    srhc_chan_if #(.t_payload(t_in_item))  item_ch ();
    srhc_chan_if #(.t_payload(t_out_item)) res_ch ();

    signature_rule_header_classifier #(
        .RULE_COUNT    (NUM_RULES),
        .SLOTS_PER_LIST(SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(res_ch)
    );

    // bench copy of the rule table
    logic [15:0] rule_hdr [NUM_RULES];
    logic [31:0] slot_lo  [NUM_RULES][LIST_COUNT][SLOTS];
    logic [31:0] slot_hi  [NUM_RULES][LIST_COUNT][SLOTS];
    bit          slot_en  [NUM_RULES][LIST_COUNT][SLOTS];

    // verdicts still owed by the block, oldest first
    t_out_item verdicts_due [$];

    // directed table, walked in order
    t_step directed_rows [$];

    int  error_count  = 0;
    int  random_sent  = 0;
    int  src_rate     = 15;  // percent chance per transaction of a sender gap
    int  sink_rate    = 15;  // percent chance per cycle of a receiver stall
    bit  hold_request = 1'b0;
    int  rate_menu [3] = '{0, 10, 35};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // queue helpers
    // ------------------------------------------------------------------

    function automatic void owe_verdict(input t_out_item v);
        verdicts_due.insert(verdicts_due.size(), v);
    endfunction

    function automatic void add_step(input t_in_item item, input bit typed,
                                     input t_out_item want);
        t_step row;
        row.item  = item;
        row.typed = typed;
        row.want  = want;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic string verdict_text(input t_out_item v);
        return $sformatf("m=%0b i=%0d a=%0d l=%0b", v.matched, v.match_index,
                         v.match_action, v.last);
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // a list hits when its any flag is set or an enabled slot holds the value,
    // then the negate flag flips the answer
    function automatic bit list_hits(input int r, input int lst, input logic [31:0] v);
        bit hit;
        hit = rule_hdr[r][HDR_ANY_LSB + lst];
        if (!hit) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (slot_en[r][lst][s] && v >= slot_lo[r][lst][s] && v <= slot_hi[r][lst][s])
                    hit = 1'b1;
            end
        end
        return hit ^ rule_hdr[r][HDR_NEG_LSB + lst];
    endfunction

    function automatic bit protocol_passes(input logic [2:0] proto, input logic [3:0] kind,
                                           input logic [7:0] ipp, input logic [15:0] sp,
                                           input logic [15:0] dp);
        if (proto == PROTO_ANY)
            return 1'b1;
        if (!kind[KIND_IPV4])
            return 1'b0;
        case (proto)
            PROTO_IP:   return 1'b1;
            PROTO_TCP:  return kind[KIND_TCP];
            PROTO_UDP:  return kind[KIND_UDP];
            PROTO_ICMP: return ipp == IP_PROTO_ICMP;
            PROTO_DNS:  return kind[KIND_DNS];
            PROTO_HTTP: return kind[KIND_TCP] && (dp == PORT_HTTP || dp == PORT_HTTPS ||
                                                  sp == PORT_HTTP || sp == PORT_HTTPS);
            default:    return 1'b0;  // protocol seven never matches
        endcase
    endfunction

    // apply one accepted transaction: writes update the table, a classify
    // queues every matching rule in index order or the single no-match verdict
    function automatic void predict_verdicts(input t_in_item it);
        logic [15:0] hdr;
        logic [15:0] sp;
        logic [15:0] dp;
        bit          fwd;
        bit          rev;
        bit          hit_rule [NUM_RULES];
        int          last_hit;
        int          found;
        t_out_item   v;
        last_hit = -1;
        found    = 0;
        case (it.mode)
            MODE_HEADER: rule_hdr[it.rule_index] = {it.rule_protocol, it.rule_flags};
            MODE_SLOT: begin
                slot_lo[it.rule_index][it.list_select][it.slot] = it.value_a;
                slot_hi[it.rule_index][it.list_select][it.slot] = it.value_b;
                slot_en[it.rule_index][it.list_select][it.slot] = it.rule_flags[0];
            end
            MODE_CLASSIFY: begin
                // ports only count when a transport header is present
                if (it.packet_kind[KIND_TCP] || it.packet_kind[KIND_UDP]) begin
                    sp = it.src_port;
                    dp = it.dst_port;
                end else begin
                    sp = '0;
                    dp = '0;
                end
                for (int r = 0; r < NUM_RULES; r++) begin
                    hdr         = rule_hdr[r];
                    hit_rule[r] = 1'b0;
                    if (hdr[HDR_VALID] && it.packet_kind[KIND_IPV4] &&
                        protocol_passes(hdr[HDR_PROTO_LSB +: 3], it.packet_kind,
                                        it.ip_protocol, sp, dp)) begin
                        fwd = list_hits(r, LIST_SRC_ADDR, it.value_a) &&
                              list_hits(r, LIST_DST_ADDR, it.value_b) &&
                              list_hits(r, LIST_SRC_PORT, {16'd0, sp}) &&
                              list_hits(r, LIST_DST_PORT, {16'd0, dp});
                        rev = hdr[HDR_BIDIR] &&
                              list_hits(r, LIST_SRC_ADDR, it.value_b) &&
                              list_hits(r, LIST_DST_ADDR, it.value_a) &&
                              list_hits(r, LIST_SRC_PORT, {16'd0, dp}) &&
                              list_hits(r, LIST_DST_PORT, {16'd0, sp});
                        hit_rule[r] = fwd || rev;
                    end
                    if (hit_rule[r] && found < MAX_VERDICTS) begin
                        found++;
                        last_hit = r;
                    end
                end
                for (int r = 0; r <= last_hit; r++) begin
                    if (hit_rule[r]) begin
                        v.matched      = 1'b1;
                        v.match_index  = 4'(r);
                        v.match_action = rule_hdr[r][HDR_ACT_LSB +: 3];
                        v.last         = (r == last_hit);
                        owe_verdict(v);
                    end
                end
                if (found == 0)
                    owe_verdict(NO_MATCH);
            end
            default: ;  // unused mode is dropped by the block
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus builders; fields the mode ignores carry random noise
    // ------------------------------------------------------------------

    function automatic t_in_item noise_item();
        t_in_item it;
        it.mode          = 2'($urandom);
        it.rule_index    = 4'($urandom);
        it.list_select   = 2'($urandom);
        it.slot          = 2'($urandom);
        it.value_a       = $urandom;
        it.value_b       = $urandom;
        it.src_port      = 16'($urandom);
        it.dst_port      = 16'($urandom);
        it.rule_protocol = 3'($urandom);
        it.rule_flags    = 13'($urandom);
        it.packet_kind   = 4'($urandom);
        it.ip_protocol   = 8'($urandom);
        return it;
    endfunction

    function automatic logic [12:0] flags_of(input bit valid, input bit bidir,
                                             input logic [3:0] any_mask,
                                             input logic [3:0] neg_mask,
                                             input logic [2:0] action);
        return {action, neg_mask, any_mask, bidir, valid};
    endfunction

    function automatic t_in_item hdr_item(input logic [3:0] idx, input logic [2:0] proto,
                                          input logic [12:0] flags);
        t_in_item it;
        it               = noise_item();
        it.mode          = MODE_HEADER;
        it.rule_index    = idx;
        it.rule_protocol = proto;
        it.rule_flags    = flags;
        return it;
    endfunction

    function automatic t_in_item slot_item(input logic [3:0] idx, input logic [1:0] lst,
                                           input logic [1:0] slot, input logic [31:0] lo,
                                           input logic [31:0] hi, input bit enable);
        t_in_item it;
        it               = noise_item();
        it.mode          = MODE_SLOT;
        it.rule_index    = idx;
        it.list_select   = lst;
        it.slot          = slot;
        it.value_a       = lo;
        it.value_b       = hi;
        it.rule_flags[0] = enable;
        return it;
    endfunction

    function automatic t_in_item pkt_item(input logic [31:0] sa, input logic [31:0] da,
                                          input logic [15:0] sp, input logic [15:0] dp,
                                          input logic [3:0] kind, input logic [7:0] ipp);
        t_in_item it;
        it             = noise_item();
        it.mode        = MODE_CLASSIFY;
        it.value_a     = sa;
        it.value_b     = da;
        it.src_port    = sp;
        it.dst_port    = dp;
        it.packet_kind = kind;
        it.ip_protocol = ipp;
        return it;
    endfunction

    function automatic logic [3:0] random_mask(input int pct);
        logic [3:0] m;
        for (int b = 0; b < 4; b++)
            m[b] = ($urandom_range(0, 99) < pct);
        return m;
    endfunction

    // ------------------------------------------------------------------
    // sender side: drive at the falling edge, see the transaction at the rising edge
    // ------------------------------------------------------------------

    // valid stays high between back-to-back transactions and only drops in a gap
    task automatic offer(input t_in_item it);
        int gap;
        @(negedge i_clk);
        if (src_rate != 0 && $urandom_range(0, 99) < src_rate) begin
            gap = $urandom_range(1, 19);
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!(item_ch.valid && item_ch.ready))
            @(posedge i_clk);
    endtask

    task automatic send_checked(input t_in_item it);
        offer(it);
        predict_verdicts(it);
        if (it.mode != MODE_UNUSED)
            random_sent++;
    endtask

    // sender goes quiet until every owed verdict has been taken
    task automatic wait_for_verdicts();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stall bursts, plus one long hold when asked
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (sink_rate != 0 && $urandom_range(0, 99) < sink_rate) begin
                stall_left   = $urandom_range(1, 19) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker: every transaction on the result side against the oldest verdict
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.payload;
            if (verdicts_due.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %s",
                         $time, verdict_text(got));
            end else begin
                want = verdicts_due.pop_front();
                if (got.matched !== want.matched || got.match_index !== want.match_index ||
                    got.match_action !== want.match_action || got.last !== want.last) begin
                    error_count++;
                    $display("%0t: result mismatch, expected %s, actual %s",
                             $time, verdict_text(want), verdict_text(got));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction means the block has hung
    // ------------------------------------------------------------------
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_signature_rule_header_classifier: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_in_item    it;
        logic [31:0] addr_pool [8];
        logic [15:0] port_pool [8];
        logic [31:0] centre;
        logic [31:0] top;
        logic [31:0] span;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tmp;
        logic [3:0]  kind;
        int          phase;
        int          lst;

        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        i_rst_n         = 1'b0;
        for (int r = 0; r < NUM_RULES; r++) begin
            rule_hdr[r] = '0;
            for (int l = 0; l < LIST_COUNT; l++)
                for (int s = 0; s < SLOTS; s++) begin
                    slot_lo[r][l][s] = '0;
                    slot_hi[r][l][s] = '0;
                    slot_en[r][l][s] = 1'b0;
                end
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        // empty table after reset: the no-match verdict even for an all-ones packet
        add_step(pkt_item('1, '1, '1, '1, KIND_ALL, 8'hFF), 1'b1, NO_MATCH);
        // unused mode is swallowed without a verdict
        it      = noise_item();
        it.mode = MODE_UNUSED;
        add_step(it, 1'b0, NO_MATCH);
        // rule 0 matches anything on ipv4
        add_step(hdr_item(4'd0, PROTO_ANY, flags_of(1'b1, 1'b0, 4'hF, 4'h0, ACT_LOG)),
                 1'b0, NO_MATCH);
        add_step(pkt_item('0, '0, '0, '0, KIND_V4_ONLY, 8'd0), 1'b1,
                 t_out_item'{matched: 1'b1, match_index: 4'd0, match_action: ACT_LOG,
                             last: 1'b1});
        // no ipv4 header: nothing can match, not even protocol any
        add_step(pkt_item($urandom, $urandom, 16'($urandom), 16'($urandom),
                          KIND_NO_V4, 8'($urandom)), 1'b1, NO_MATCH);
        // rule 15: bidirectional http with a range in every list, top action
        add_step(hdr_item(4'd15, PROTO_HTTP,
                          flags_of(1'b1, 1'b1, 4'h0, 4'h0, ACT_UNDEF_HI)),
                 1'b0, NO_MATCH);
        add_step(slot_item(4'd15, LIST_SRC_ADDR, 2'd0, '0, '0, 1'b1), 1'b0, NO_MATCH);
        add_step(slot_item(4'd15, LIST_DST_ADDR, 2'd3, '1, '1, 1'b1), 1'b0, NO_MATCH);
        add_step(slot_item(4'd15, LIST_SRC_PORT, 2'd1, 32'(PORT_HTTP), 32'(PORT_HTTP),
                           1'b1), 1'b0, NO_MATCH);
        add_step(slot_item(4'd15, LIST_DST_PORT, 2'd2, 32'd1000, 32'd2000, 1'b1),
                 1'b0, NO_MATCH);
        // forward hit, reverse hit, then udp which http refuses
        add_step(pkt_item('0, '1, PORT_HTTP, 16'd1500, KIND_V4_TCP, 8'd6), 1'b0, NO_MATCH);
        add_step(pkt_item('1, '0, 16'd1500, PORT_HTTP, KIND_V4_TCP, 8'd6), 1'b0, NO_MATCH);
        add_step(pkt_item('0, '1, PORT_HTTP, 16'd1500, KIND_V4_UDP, 8'd17), 1'b0, NO_MATCH);
        // inverted range holds nothing
        add_step(slot_item(4'd15, LIST_DST_PORT, 2'd2, 32'd2000, 32'd1000, 1'b1),
                 1'b0, NO_MATCH);
        add_step(pkt_item('0, '1, PORT_HTTP, 16'd1500, KIND_V4_TCP, 8'd6), 1'b0, NO_MATCH);
        // icmp rule with every list negated and no slots: negated miss is a hit
        add_step(hdr_item(4'd7, PROTO_ICMP, flags_of(1'b1, 1'b0, 4'h0, 4'hF, ACT_ALERT)),
                 1'b0, NO_MATCH);
        add_step(pkt_item(32'h0102_0304, 32'h0506_0708, '0, '0, KIND_V4_ONLY,
                          IP_PROTO_ICMP), 1'b0, NO_MATCH);
        add_step(pkt_item(32'h0102_0304, 32'h0506_0708, '0, '0, KIND_V4_ONLY, 8'd2),
                 1'b0, NO_MATCH);
        // protocol seven is stored but never matches; dns rule with a spare action
        add_step(hdr_item(4'd3, PROTO_RESERVED,
                          flags_of(1'b1, 1'b1, 4'hF, 4'h0, ACT_PASS)),
                 1'b0, NO_MATCH);
        add_step(hdr_item(4'd4, PROTO_DNS, flags_of(1'b1, 1'b0, 4'hF, 4'h0, ACT_UNDEF_LO)),
                 1'b0, NO_MATCH);
        add_step(pkt_item($urandom, $urandom, 16'd53, 16'd53, KIND_V4_DNS, 8'd17),
                 1'b0, NO_MATCH);
        // every flag set: any then negate, so the rule can never hit
        add_step(hdr_item(4'd1, PROTO_HTTP, '1), 1'b0, NO_MATCH);
        add_step(pkt_item('1, '0, PORT_HTTPS, '0, KIND_ALL, IP_PROTO_ICMP), 1'b0, NO_MATCH);
        // drop rule 0, then a packet whose ports vanish for lack of tcp/udp
        add_step(hdr_item(4'd0, PROTO_ANY, '0), 1'b0, NO_MATCH);
        add_step(pkt_item('0, '1, PORT_HTTP, 16'd1500, KIND_V4_ONLY, 8'd6), 1'b0, NO_MATCH);

        foreach (directed_rows[n]) begin
            offer(directed_rows[n].item);
            if (directed_rows[n].typed)
                owe_verdict(directed_rows[n].want);
            else
                predict_verdicts(directed_rows[n].item);
        end

        // pools so that ranges and packets land on each other often
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        port_pool[0] = '0;
        port_pool[1] = '1;
        port_pool[2] = PORT_HTTP;
        port_pool[3] = PORT_HTTPS;
        for (int p = 2; p < 8; p++)
            addr_pool[p] = $urandom;
        for (int p = 4; p < 8; p++)
            port_pool[p] = 16'($urandom);

        // random phases: rewrite a few rules and slots, then classify a burst of packets
        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            phase++;
            if (RANDOM_ITEMS - random_sent <= QUIET_TAIL) begin
                src_rate  = 0;
                sink_rate = 0;
            end else begin
                src_rate  = rate_menu[$urandom_range(0, 2)];
                sink_rate = rate_menu[$urandom_range(0, 2)];
            end
            // sender stops until the block has handed back everything it owes
            if (phase % 9 == 5)
                wait_for_verdicts();

            repeat ($urandom_range(1, 3))
                send_checked(hdr_item(4'($urandom), 3'($urandom),
                                      flags_of($urandom_range(0, 99) < 85, 1'($urandom),
                                               random_mask(40), random_mask(15),
                                               3'($urandom))));

            repeat ($urandom_range(0, 6)) begin
                lst = $urandom_range(0, 3);
                if (lst == LIST_SRC_ADDR || lst == LIST_DST_ADDR) begin
                    centre = addr_pool[$urandom_range(0, 7)];
                    top    = '1;
                    case ($urandom_range(0, 3))
                        0:       span = 32'd0;
                        1:       span = 32'd255;
                        2:       span = 32'd65535;
                        default: span = 32'h00FF_FFFF;
                    endcase
                end else begin
                    centre = {16'd0, port_pool[$urandom_range(0, 7)]};
                    top    = 32'h0000_FFFF;
                    case ($urandom_range(0, 2))
                        0:       span = 32'd0;
                        1:       span = 32'd15;
                        default: span = 32'd1000;
                    endcase
                end
                lo = (centre > span) ? centre - span : 32'd0;
                hi = (top - centre > span) ? centre + span : top;
                case ($urandom_range(0, 11))
                    0: begin  // inverted
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                    1: begin  // everything
                        lo = '0;
                        hi = '1;
                    end
                    2: begin  // anything at all
                        lo = $urandom;
                        hi = $urandom;
                    end
                    default: ;
                endcase
                send_checked(slot_item(4'($urandom), 2'(lst), 2'($urandom), lo, hi,
                                       $urandom_range(0, 9) != 0));
            end

            if ($urandom_range(0, 5) == 0) begin
                it      = noise_item();
                it.mode = MODE_UNUSED;
                send_checked(it);
            end

            // long receiver hold while packets keep coming, so the block backs up
            if (phase % 7 == 3 && RANDOM_ITEMS - random_sent > QUIET_TAIL)
                hold_request = 1'b1;

            repeat ((phase % 7 == 3) ? 16 : $urandom_range(3, 10)) begin
                kind = 4'($urandom);
                if ($urandom_range(0, 9) != 0)
                    kind[KIND_IPV4] = 1'b1;
                send_checked(pkt_item(
                    ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom,
                    ($urandom_range(0, 3) != 0) ? addr_pool[$urandom_range(0, 7)] : $urandom,
                    ($urandom_range(0, 3) != 0) ? port_pool[$urandom_range(0, 7)]
                                                : 16'($urandom),
                    ($urandom_range(0, 3) != 0) ? port_pool[$urandom_range(0, 7)]
                                                : 16'($urandom),
                    kind,
                    ($urandom_range(0, 9) < 3) ? IP_PROTO_ICMP : 8'($urandom)));
            end
        end

        // drain, then give trailing writes and any stray result time to show up
        wait_for_verdicts();
        repeat (END_SETTLE) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_signature_rule_header_classifier: clean");
        else
            $display("tb_signature_rule_header_classifier: errors");
        $finish;
    end

endmodule
